@@ src/text_console_writer_top_assert.svh @@
// assertion macros shared by the console writer modules
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tcw_pkg.sv @@
package tcw_pkg;

    // default screen geometry
    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 25;

    // request and result field widths
    localparam int OP_W   = 2;
    localparam int CHR_W  = 8;
    localparam int IDX_W  = 11;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;

    // cell codes
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
    localparam logic [CHR_W-1:0]  NEWLINE_CODE = 8'h0A;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // commands from the sequencer to the cursor unit
    typedef struct packed {
        logic step;
        logic newline;
        logic home;
    } cur_cmd_t;

endpackage

@@ src/tcw_ram.sv @@
module tcw_ram #(
    parameter int WIDTH = tcw_pkg::CELL_W,
    parameter int DEPTH = tcw_pkg::COLS_DEF * tcw_pkg::ROWS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/tcw_cursor.sv @@
module tcw_cursor #(
    parameter int COLS = tcw_pkg::COLS_DEF,
    parameter int ROWS = tcw_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcw_pkg::cur_cmd_t             cmd,
    output logic [$clog2(COLS)-1:0]       col,
    output logic [$clog2(ROWS)-1:0]       row,
    output logic [$clog2(COLS*ROWS)-1:0]  pos,
    output logic                          scroll
);

    localparam int CW = $clog2(COLS);
    localparam int RW = $clog2(ROWS);
    localparam int AW = $clog2(COLS * ROWS);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          last_col;
    logic          last_row;

    assign last_col = (32'(col_reg) == COLS - 1);
    assign last_row = (32'(row_reg) == ROWS - 1);

    // advance, wrap and home; past the last row the row stays put and a scroll is flagged
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        scroll   = 1'b0;
        if (cmd.home)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (cmd.step)
        begin
            if (cmd.newline || last_col)
            begin
                col_next = '0;
                if (last_row)
                begin
                    scroll = 1'b1;
                end
                else
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // linear position
    assign pos = AW'(32'(row_reg) * COLS + 32'(col_reg));
    assign col = col_reg;
    assign row = row_reg;

`include "text_console_writer_top_assert.svh"

    `TCW_ASSERT_NOW(a_cursor_in_range, 1'b1, (32'(col_reg) < COLS) && (32'(row_reg) < ROWS), "cursor out of screen")
    `TCW_ASSERT_NEXT(a_scroll_keeps_last_row, scroll, last_row && (col_reg == '0), "scroll left cursor off the bottom row start")

endmodule

@@ src/text_console_writer_top.sv @@
// Text console writer: an 80x25 (COLS x ROWS) screen of 16-bit cells (attribute in the high
// byte, character in the low byte) with a cursor, behind a valid/stall request channel and a
// valid/stall result channel. Each request gives exactly one result carrying the cursor column,
// row and linear position after the operation, plus the cell contents for a read (zero
// otherwise, and zero for an index past the screen). A put or a read steps through its own state and
// the done state; a clear and a put that scrolls are paced by the single write port of the screen
// memory, which one address walker sweeps a cell per cycle. After reset the walker blanks the
// whole screen before the first request is taken. The block holds one request at a time; a
// finished result sits in the output register while the next request runs.
module text_console_writer_top #(
    parameter int COLS = tcw_pkg::COLS_DEF,
    parameter int ROWS = tcw_pkg::ROWS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tcw_pkg::OP_W-1:0]    op,
    input  logic [tcw_pkg::CHR_W-1:0]   char_code,
    input  logic [tcw_pkg::CHR_W-1:0]   color,
    input  logic [tcw_pkg::IDX_W-1:0]   cell_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tcw_pkg::COL_W-1:0]   cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
    output logic [tcw_pkg::POS_W-1:0]   cursor_pos,
    output logic [tcw_pkg::CELL_W-1:0]  cell_value
);

    localparam int NCELLS = COLS * ROWS;
    localparam int CW     = $clog2(COLS);
    localparam int RW     = $clog2(ROWS);
    localparam int AW     = $clog2(NCELLS);
    localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);
    localparam logic [AW-1:0] LAST_COPY = AW'(NCELLS - COLS - 1);
    localparam logic [AW-1:0] FILL_BASE = AW'(NCELLS - COLS);

    typedef enum logic [6:0] {
        S_INIT = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_PUT  = 7'b0000100,
        S_READ = 7'b0001000,
        S_COPY = 7'b0010000,
        S_FILL = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]               walk_reg, walk_next;
    logic [AW-1:0]               wr_addr_reg, wr_addr_next;
    logic                        pend_reg, pend_next;
    logic [tcw_pkg::CHR_W-1:0]   char_reg, char_next;
    logic [tcw_pkg::CHR_W-1:0]   color_reg, color_next;
    logic                        range_reg, range_next;
    logic [tcw_pkg::CELL_W-1:0]  value_reg, value_next;

    logic                        out_valid_reg, out_valid_next;
    logic [tcw_pkg::COL_W-1:0]   col_out_reg, col_out_next;
    logic [tcw_pkg::ROW_W-1:0]   row_out_reg, row_out_next;
    logic [tcw_pkg::POS_W-1:0]   pos_out_reg, pos_out_next;
    logic [tcw_pkg::CELL_W-1:0]  cell_out_reg, cell_out_next;

    logic                        accept;
    logic                        load;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

    tcw_pkg::cur_cmd_t           cur_cmd;
    logic [CW-1:0]               cur_col;
    logic [RW-1:0]               cur_row;
    logic [AW-1:0]               cur_pos;
    logic                        cur_scroll;
    logic [31:0]                 col_w;
    logic [31:0]                 row_w;
    logic [31:0]                 pos_w;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign load     = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // screen memory
    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (NCELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // cursor unit
    assign cur_cmd.step    = (state_reg == S_PUT);
    assign cur_cmd.newline = (char_reg == tcw_pkg::NEWLINE_CODE);
    assign cur_cmd.home    = accept && (op == tcw_pkg::OP_CLEAR);

    tcw_cursor #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_cursor (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cur_cmd),
        .col    (cur_col),
        .row    (cur_row),
        .pos    (cur_pos),
        .scroll (cur_scroll)
    );

    // read port: request index while idle, source row while copying
    assign ram_raddr = (state_reg == S_COPY) ? AW'(32'(walk_reg) + COLS) : AW'(cell_index);

    // sequencer and address walker
    always_comb
    begin
        state_next   = state_reg;
        walk_next    = walk_reg;
        wr_addr_next = wr_addr_reg;
        pend_next    = pend_reg;
        char_next    = char_reg;
        color_next   = color_reg;
        range_next   = range_reg;
        value_next   = value_reg;
        ram_we       = 1'b0;
        ram_waddr    = walk_reg;
        ram_wdata    = tcw_pkg::BLANK_CELL;
        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                walk_next = walk_reg + AW'(1);
                if (walk_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    char_next  = char_code;
                    color_next = color;
                    range_next = (32'(cell_index) < NCELLS);
                    value_next = '0;
                    walk_next  = '0;
                    pend_next  = 1'b0;
                    case (op)
                        tcw_pkg::OP_PUT:   state_next = S_PUT;
                        tcw_pkg::OP_CLEAR: state_next = S_FILL;
                        tcw_pkg::OP_READ:  state_next = S_READ;
                        default:           state_next = S_DONE;
                    endcase
                end
            end
            S_PUT:
            begin
                ram_we    = !cur_cmd.newline;
                ram_waddr = cur_pos;
                ram_wdata = {color_reg, char_reg};
                if (cur_scroll)
                begin
                    state_next = S_COPY;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                value_next = range_reg ? ram_rdata : '0;
                state_next = S_DONE;
            end
            S_COPY:
            begin
                // write back the cell read last cycle, fetch the next one
                ram_we       = pend_reg;
                ram_waddr    = wr_addr_reg;
                ram_wdata    = ram_rdata;
                pend_next    = 1'b1;
                wr_addr_next = walk_reg;
                if (walk_reg == LAST_COPY)
                begin
                    walk_next  = FILL_BASE;
                    state_next = S_FILL;
                end
                else
                begin
                    walk_next = walk_reg + AW'(1);
                end
            end
            S_FILL:
            begin
                if (pend_reg)
                begin
                    // drain the last copied cell first
                    ram_we    = 1'b1;
                    ram_waddr = wr_addr_reg;
                    ram_wdata = ram_rdata;
                    pend_next = 1'b0;
                end
                else
                begin
                    ram_we    = 1'b1;
                    walk_next = walk_reg + AW'(1);
                    if (walk_reg == LAST_CELL)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register
    assign col_w = 32'(cur_col);
    assign row_w = 32'(cur_row);
    assign pos_w = 32'(cur_pos);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        col_out_next   = col_out_reg;
        row_out_next   = row_out_reg;
        pos_out_next   = pos_out_reg;
        cell_out_next  = cell_out_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            col_out_next   = col_w[tcw_pkg::COL_W-1:0];
            row_out_next   = row_w[tcw_pkg::ROW_W-1:0];
            pos_out_next   = pos_w[tcw_pkg::POS_W-1:0];
            cell_out_next  = value_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            walk_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        wr_addr_reg  <= wr_addr_next;
        char_reg     <= char_next;
        color_reg    <= color_next;
        range_reg    <= range_next;
        value_reg    <= value_next;
        col_out_reg  <= col_out_next;
        row_out_reg  <= row_out_next;
        pos_out_reg  <= pos_out_next;
        cell_out_reg <= cell_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign cursor_col = col_out_reg;
    assign cursor_row = row_out_reg;
    assign cursor_pos = pos_out_reg;
    assign cell_value = cell_out_reg;

`include "text_console_writer_top_assert.svh"

    `TCW_ASSERT_NOW(a_no_write_when_idle,
        (state_reg == S_IDLE) || (state_reg == S_DONE) || (state_reg == S_READ),
        !ram_we, "screen written outside a write phase")
    `TCW_ASSERT_NOW(a_result_from_done, $rose(out_valid_reg), $past(state_reg == S_DONE),
        "result raised outside the done state")
    `TCW_ASSERT_NOW(a_copy_on_last_row, state_reg == S_COPY, 32'(cur_row) == ROWS - 1,
        "scroll running with cursor off the bottom row")
    `TCW_ASSERT_NEXT(a_put_one_cycle, state_reg == S_PUT,
        (state_reg == S_DONE) || (state_reg == S_COPY), "put did not finish in one cycle")

endmodule
